@@ hdl/amts_pkg.sv @@
// ----------------------------------------------------------------------------
// amts_pkg
// Shared types and constants for the auxiliary motor trajectory sequencer:
// field widths, operation and mode codes, and register reset values.
// ----------------------------------------------------------------------------
package amts_pkg;

	// Field widths.
	localparam int unsigned OpW     = 3;
	localparam int unsigned PosW    = 16;
	localparam int unsigned SpeedW  = 8;
	localparam int unsigned WordW   = 32;
	localparam int unsigned CountW  = 8;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDatW = 16;

	// Operation codes carried by an input item.
	typedef enum logic [OpW-1:0] {
		OP_TICK          = 3'd0,
		OP_START_SPEED   = 3'd1,
		OP_START_GOTO    = 3'd2,
		OP_FIND_ZERO     = 3'd3,
		OP_FIND_ZERO_REV = 3'd4,
		OP_FIND_LIMIT    = 3'd5
	} op_t;

	// Trajectory modes.
	typedef enum logic [2:0] {
		MODE_DONE         = 3'd0,
		MODE_SPEED        = 3'd1,
		MODE_GOTO         = 3'd2,
		MODE_UNBLOCK      = 3'd3,
		MODE_ZERO_NOT     = 3'd4,
		MODE_ZERO_NOT_REV = 3'd5,
		MODE_ZERO         = 3'd6,
		MODE_LIMIT        = 3'd7
	} mode_t;

	// Command kinds.
	typedef enum logic [1:0] {
		CMD_NONE   = 2'd0,
		CMD_SPEED  = 2'd1,
		CMD_TARGET = 2'd2
	} cmd_kind_t;

	// Mode-set requests.
	typedef enum logic [1:0] {
		REQ_NONE       = 2'd0,
		REQ_TRAJ       = 2'd1,
		REQ_TRAJ_BLOCK = 2'd2,
		REQ_OFF        = 2'd3
	} req_t;

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		REG_HANDLE_BLOCKING  = 2'd0,
		REG_BACKOFF_DISTANCE = 2'd1,
		REG_UNBLOCK_WAIT     = 2'd2,
		REG_ARRIVAL_WINDOW   = 2'd3
	} reg_idx_t;

	// Register reset values.
	localparam logic signed [PosW-1:0] BackoffReset = -16'sd250;
	localparam logic [CountW-1:0]      UnblockReset = 8'd112;
	localparam logic [PosW-1:0]        WindowReset  = 16'd300;

	// Speed reversal, saturating so that the most negative speed becomes the
	// most positive one.
	function automatic logic [SpeedW-1:0] neg_sat(input logic [SpeedW-1:0] v);
		logic [SpeedW-1:0] r;
		if (v == {1'b1, {(SpeedW-1){1'b0}}}) begin
			r = {1'b0, {(SpeedW-1){1'b1}}};
		end else begin
			r = -v;
		end
		return r;
	endfunction

endpackage

@@ hdl/amts_in_if.sv @@
// ----------------------------------------------------------------------------
// amts_in_if
// Input item channel: an operation with the sensor and controller readings
// that go with it.
// ----------------------------------------------------------------------------
interface amts_in_if;
	import amts_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OpW-1:0]           op;
	logic [PosW-1:0]          goto_position;
	logic signed [SpeedW-1:0] start_speed;
	logic signed [PosW-1:0]   encoder_diff;
	logic                     zero_seen;
	logic                     blocked;
	logic                     traj_enabled;
	logic                     speed_use_pos;
	logic signed [WordW-1:0]  target_readback;
	logic signed [WordW-1:0]  pos_consign;
	logic signed [WordW-1:0]  pos_current;

	modport source (
		output valid, op, goto_position, start_speed, encoder_diff, zero_seen,
		       blocked, traj_enabled, speed_use_pos, target_readback,
		       pos_consign, pos_current,
		input  ready
	);

	modport sink (
		input  valid, op, goto_position, start_speed, encoder_diff, zero_seen,
		       blocked, traj_enabled, speed_use_pos, target_readback,
		       pos_consign, pos_current,
		output ready
	);

endinterface

@@ hdl/amts_out_if.sv @@
// ----------------------------------------------------------------------------
// amts_out_if
// Result item channel: mode, position and the commands issued by one step.
// ----------------------------------------------------------------------------
interface amts_out_if;
	import amts_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [2:0]              mode_now;
	logic [PosW-1:0]         aux_position;
	logic [1:0]              cmd_kind;
	logic signed [WordW-1:0] cmd_value;
	logic [1:0]              mode_request;
	logic                    finished;
	logic                    output_off;

	modport source (
		output valid, mode_now, aux_position, cmd_kind, cmd_value, mode_request,
		       finished, output_off,
		input  ready
	);

	modport sink (
		input  valid, mode_now, aux_position, cmd_kind, cmd_value, mode_request,
		       finished, output_off,
		output ready
	);

endinterface

@@ hdl/amts_cfg_if.sv @@
// ----------------------------------------------------------------------------
// amts_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface amts_cfg_if;
	import amts_pkg::*;

	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [CfgDatW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);

endinterface

@@ hdl/aux_motor_trajectory_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// aux_motor_trajectory_sequencer_unit
// Trajectory sequencer for one auxiliary motor: position tracking, goto with
// blocking back-off, find zero and find limit.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the result side keeps up.
// The item is captured in an input register, the mode and position update is
// one pass of logic on the held state, and the result is captured in an
// output register. The throughput is set by that state update loop, so items
// may follow each other in every cycle unless the result side stalls; while a
// result waits to be taken, one more item is still accepted into the input
// register. Configuration writes are taken in any cycle.
module aux_motor_trajectory_sequencer_unit (
	input logic clk,
	input logic arst_n,
	amts_in_if.sink    item,
	amts_out_if.source result,
	amts_cfg_if.sink   cfg
);
	import amts_pkg::*;

	// Held copy of an accepted input item.
	typedef struct packed {
		logic [OpW-1:0]    op;
		logic [PosW-1:0]   goto_position;
		logic [SpeedW-1:0] start_speed;
		logic [PosW-1:0]   encoder_diff;
		logic              zero_seen;
		logic              blocked;
		logic              traj_enabled;
		logic              speed_use_pos;
		logic [WordW-1:0]  target_readback;
		logic [WordW-1:0]  pos_consign;
		logic [WordW-1:0]  pos_current;
	} item_t;

	// Configuration registers.
	logic              handle_blocking_q;
	logic [PosW-1:0]   backoff_q;
	logic [CountW-1:0] unblock_wait_q;
	logic [PosW-1:0]   window_q;

	// Input stage.
	logic  valid_s1;
	item_t item_s1;

	// Sequencer state.
	mode_t             mode_q, mode_d;
	logic [PosW-1:0]   pos_q, pos_d;
	logic [WordW-1:0]  target_q, target_d;
	logic [CountW-1:0] ucnt_q, ucnt_d;
	logic [SpeedW-1:0] speed_q, speed_d;

	// Step outputs.
	cmd_kind_t        kind_d;
	logic [WordW-1:0] value_d;
	req_t             req_d;
	logic             fin_d;
	logic             off_d;

	// Output register.
	logic             out_valid_q;
	mode_t            out_mode_q;
	logic [PosW-1:0]  out_pos_q;
	cmd_kind_t        out_kind_q;
	logic [WordW-1:0] out_value_q;
	req_t             out_req_q;
	logic             out_fin_q;
	logic             out_off_q;

	// Shared arithmetic for the step.
	logic              advance;
	logic              step;
	logic [PosW-1:0]   pos_tick;
	logic [CountW-1:0] ucnt_dec;
	logic [WordW-1:0]  arr_diff;
	logic [WordW-1:0]  arr_mag;
	logic              arrived;
	logic [WordW-1:0]  backoff_tgt;
	logic [PosW-1:0]   goto_delta;
	logic [WordW-1:0]  goto_tgt;
	logic [SpeedW-1:0] speed_rev;
	logic              tick_on;

	// Handshake: the result stage moves when it is empty or being drained.
	assign advance    = !out_valid_q || result.ready;
	assign step       = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handle_blocking_q <= 1'b0;
			backoff_q         <= BackoffReset;
			unblock_wait_q    <= UnblockReset;
			window_q          <= WindowReset;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_HANDLE_BLOCKING:  handle_blocking_q <= cfg.data[0];
				REG_BACKOFF_DISTANCE: backoff_q         <= cfg.data;
				REG_UNBLOCK_WAIT:     unblock_wait_q    <= cfg.data[CountW-1:0];
				REG_ARRIVAL_WINDOW:   window_q          <= cfg.data;
				default:              ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.op              <= item.op;
			item_s1.goto_position   <= item.goto_position;
			item_s1.start_speed     <= item.start_speed;
			item_s1.encoder_diff    <= item.encoder_diff;
			item_s1.zero_seen       <= item.zero_seen;
			item_s1.blocked         <= item.blocked;
			item_s1.traj_enabled    <= item.traj_enabled;
			item_s1.speed_use_pos   <= item.speed_use_pos;
			item_s1.target_readback <= item.target_readback;
			item_s1.pos_consign     <= item.pos_consign;
			item_s1.pos_current     <= item.pos_current;
		end
	end

	// Arithmetic used by the step logic.
	assign pos_tick    = pos_q + item_s1.encoder_diff;
	assign ucnt_dec    = ucnt_q - 1'b1;
	assign arr_diff    = item_s1.target_readback - item_s1.pos_current;
	assign arr_mag     = arr_diff[WordW-1] ? (~arr_diff + 1'b1) : arr_diff;
	assign arrived     = arr_mag < {{(WordW-PosW){1'b0}}, window_q};
	assign backoff_tgt = item_s1.pos_consign
	                   + {{(WordW-PosW){backoff_q[PosW-1]}}, backoff_q};
	assign goto_delta  = item_s1.goto_position - pos_q;
	assign goto_tgt    = item_s1.pos_consign
	                   + {{(WordW-PosW){goto_delta[PosW-1]}}, goto_delta};
	assign speed_rev   = neg_sat(speed_q);
	assign tick_on     = item_s1.traj_enabled;

	// Next mode.
	always_comb begin
		mode_d = mode_q;
		case (item_s1.op)
			OP_TICK: begin
				if (tick_on) begin
					case (mode_q)
						MODE_SPEED: begin
							if (item_s1.speed_use_pos &&
							    item_s1.target_readback == item_s1.pos_consign) begin
								mode_d = MODE_DONE;
							end
						end
						MODE_GOTO: begin
							if (item_s1.blocked) begin
								mode_d = MODE_UNBLOCK;
							end else if (arrived) begin
								mode_d = MODE_DONE;
							end
						end
						MODE_UNBLOCK: begin
							if (ucnt_dec == '0) begin
								mode_d = MODE_GOTO;
							end
						end
						MODE_ZERO_NOT, MODE_ZERO_NOT_REV: begin
							if (item_s1.zero_seen) begin
								mode_d = MODE_ZERO;
							end
						end
						MODE_ZERO: begin
							if (!item_s1.zero_seen) begin
								mode_d = MODE_DONE;
							end
						end
						MODE_LIMIT: begin
							if (item_s1.blocked) begin
								mode_d = MODE_DONE;
							end
						end
						default: ;
					endcase
				end
			end
			OP_START_SPEED:   mode_d = MODE_SPEED;
			OP_START_GOTO:    mode_d = MODE_GOTO;
			OP_FIND_ZERO:     mode_d = MODE_ZERO_NOT;
			OP_FIND_ZERO_REV: mode_d = MODE_ZERO_NOT_REV;
			OP_FIND_LIMIT:    mode_d = MODE_LIMIT;
			default:          ;
		endcase
	end

	// Data state and step outputs.
	always_comb begin
		pos_d    = pos_q;
		target_d = target_q;
		ucnt_d   = ucnt_q;
		speed_d  = speed_q;
		kind_d   = CMD_NONE;
		value_d  = '0;
		req_d    = REQ_NONE;
		fin_d    = 1'b0;
		off_d    = 1'b0;
		case (item_s1.op)
			OP_TICK: begin
				pos_d = pos_tick;
				if (tick_on) begin
					case (mode_q)
						MODE_SPEED: begin
							if (item_s1.speed_use_pos &&
							    item_s1.target_readback == item_s1.pos_consign) begin
								fin_d = 1'b1;
							end
						end
						MODE_GOTO: begin
							if (item_s1.blocked) begin
								kind_d  = CMD_TARGET;
								value_d = backoff_tgt;
								ucnt_d  = unblock_wait_q;
							end else if (arrived) begin
								fin_d = 1'b1;
							end
						end
						MODE_UNBLOCK: begin
							ucnt_d = ucnt_dec;
							if (ucnt_dec == '0) begin
								kind_d  = CMD_TARGET;
								value_d = target_q;
							end
						end
						MODE_ZERO_NOT_REV: begin
							if (item_s1.zero_seen) begin
								speed_d = speed_rev;
								kind_d  = CMD_SPEED;
								value_d = {{(WordW-SpeedW){speed_rev[SpeedW-1]}}, speed_rev};
							end
						end
						MODE_ZERO: begin
							if (!item_s1.zero_seen) begin
								speed_d = '0;
								kind_d  = CMD_SPEED;
								fin_d   = 1'b1;
								pos_d   = '0;
							end
						end
						MODE_LIMIT: begin
							if (item_s1.blocked) begin
								req_d = REQ_OFF;
								fin_d = 1'b1;
								off_d = 1'b1;
								pos_d = '0;
							end
						end
						default: ;
					endcase
				end
			end
			OP_START_SPEED: begin
				req_d = REQ_TRAJ;
			end
			OP_START_GOTO: begin
				target_d = goto_tgt;
				kind_d   = CMD_TARGET;
				value_d  = goto_tgt;
				req_d    = handle_blocking_q ? REQ_TRAJ_BLOCK : REQ_TRAJ;
			end
			OP_FIND_ZERO, OP_FIND_ZERO_REV, OP_FIND_LIMIT: begin
				speed_d = item_s1.start_speed;
				kind_d  = CMD_SPEED;
				value_d = {{(WordW-SpeedW){item_s1.start_speed[SpeedW-1]}},
				           item_s1.start_speed};
				req_d   = (item_s1.op == OP_FIND_LIMIT) ? REQ_TRAJ_BLOCK : REQ_TRAJ;
			end
			default: ;
		endcase
	end

	// Sequencer state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_DONE;
			pos_q    <= '0;
			target_q <= '0;
			ucnt_q   <= '0;
			speed_q  <= '0;
		end else if (step) begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			target_q <= target_d;
			ucnt_q   <= ucnt_d;
			speed_q  <= speed_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_mode_q  <= mode_d;
			out_pos_q   <= pos_d;
			out_kind_q  <= kind_d;
			out_value_q <= value_d;
			out_req_q   <= req_d;
			out_fin_q   <= fin_d;
			out_off_q   <= off_d;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.mode_now     = out_mode_q;
	assign result.aux_position = out_pos_q;
	assign result.cmd_kind     = out_kind_q;
	assign result.cmd_value    = out_value_q;
	assign result.mode_request = out_req_q;
	assign result.finished     = out_fin_q;
	assign result.output_off   = out_off_q;

`ifndef SYNTHESIS
	// A finished step always leaves the sequencer in the done mode.
	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_fin_q |-> out_mode_q == MODE_DONE)
		else $error("finished result with a mode other than done");

	// Forcing the output off only happens at the limit, with all modes off.
	a_off_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_off_q |-> out_req_q == REQ_OFF && out_pos_q == '0)
		else $error("output off without mode-off request and position reset");

	// The state only moves when an item passes into the result register.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(mode_q) && $stable(pos_q) && $stable(ucnt_q))
		else $error("sequencer state changed without a step");
`endif

endmodule

@@ test/amts_motion_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// amts_motion_checker
// Watches the item, result and register channels of the trajectory
// sequencer. It keeps its own copy of the mode, position and registers,
// works out the result of every accepted item and compares each delivered
// result with the oldest one still awaited.
// ----------------------------------------------------------------------------
module amts_motion_checker (
	input  logic clk,
	input  logic arst_n,
	amts_in_if   item,
	amts_out_if  result,
	amts_cfg_if  cfg,
	output int   steps_awaited,
	output int   mismatches
);
	import amts_pkg::*;

	typedef struct packed {
		mode_t            mode;
		logic [PosW-1:0]  position;
		cmd_kind_t        kind;
		logic [WordW-1:0] value;
		req_t             request;
		logic             finished;
		logic             output_off;
	} motion_step_t;

	// Register copies.
	logic              blocking_on;
	logic [PosW-1:0]   backoff;
	logic [CountW-1:0] wait_ticks;
	logic [PosW-1:0]   window;

	// Sequencer state copies.
	mode_t             mode;
	logic [PosW-1:0]   aux_pos;
	logic [WordW-1:0]  goto_target;
	logic [CountW-1:0] unblock_left;
	logic [SpeedW-1:0] speed;

	motion_step_t awaited_steps[$];
	int           result_no;

	// Speed reversal that saturates: the most negative speed turns into the
	// most positive one instead of wrapping onto itself.
	function automatic logic [SpeedW-1:0] reversed(input logic [SpeedW-1:0] v);
		if ($signed(v) == -128) begin
			return 8'sd127;
		end
		return -v;
	endfunction

	// Applies the item on the item channel to the state copies and returns
	// the result that the block has to deliver for it.
	function automatic motion_step_t next_step();
		motion_step_t     s;
		logic [WordW-1:0] delta;
		logic [WordW-1:0] mag;
		logic [PosW-1:0]  rel;
		s.kind       = CMD_NONE;
		s.value      = '0;
		s.request    = REQ_NONE;
		s.finished   = 1'b0;
		s.output_off = 1'b0;
		case (item.op)
		OP_TICK: begin
			aux_pos = aux_pos + item.encoder_diff;
			if (item.traj_enabled) begin
				case (mode)
				MODE_SPEED: begin
					if (item.speed_use_pos && item.target_readback == item.pos_consign) begin
						s.finished = 1'b1;
						mode       = MODE_DONE;
					end
				end
				MODE_GOTO: begin
					if (item.blocked) begin
						mode         = MODE_UNBLOCK;
						s.kind       = CMD_TARGET;
						s.value      = item.pos_consign + {{(WordW-PosW){backoff[PosW-1]}}, backoff};
						unblock_left = wait_ticks;
					end else begin
						// The magnitude is taken as unsigned, so the most negative
						// difference never counts as arrived.
						delta = item.target_readback - item.pos_current;
						mag   = delta[WordW-1] ? -delta : delta;
						if (mag < {{(WordW-PosW){1'b0}}, window}) begin
							mode       = MODE_DONE;
							s.finished = 1'b1;
						end
					end
				end
				MODE_UNBLOCK: begin
					unblock_left = unblock_left - 1'b1;
					if (unblock_left == '0) begin
						mode    = MODE_GOTO;
						s.kind  = CMD_TARGET;
						s.value = goto_target;
					end
				end
				MODE_ZERO_NOT: begin
					if (item.zero_seen) begin
						mode = MODE_ZERO;
					end
				end
				MODE_ZERO_NOT_REV: begin
					if (item.zero_seen) begin
						speed   = reversed(speed);
						s.kind  = CMD_SPEED;
						s.value = {{(WordW-SpeedW){speed[SpeedW-1]}}, speed};
						mode    = MODE_ZERO;
					end
				end
				MODE_ZERO: begin
					if (!item.zero_seen) begin
						speed      = '0;
						s.kind     = CMD_SPEED;
						s.finished = 1'b1;
						aux_pos    = '0;
						mode       = MODE_DONE;
					end
				end
				MODE_LIMIT: begin
					if (item.blocked) begin
						s.request    = REQ_OFF;
						s.finished   = 1'b1;
						s.output_off = 1'b1;
						aux_pos      = '0;
						mode         = MODE_DONE;
					end
				end
				default: begin
				end
				endcase
			end
		end
		OP_START_SPEED: begin
			s.request = REQ_TRAJ;
			mode      = MODE_SPEED;
		end
		OP_START_GOTO: begin
			// The destination is relative to the wrapping position, so the
			// difference is wrapped to 16 bits before it is added to the consign.
			rel         = item.goto_position - aux_pos;
			goto_target = item.pos_consign + {{(WordW-PosW){rel[PosW-1]}}, rel};
			mode        = MODE_GOTO;
			s.kind      = CMD_TARGET;
			s.value     = goto_target;
			s.request   = blocking_on ? REQ_TRAJ_BLOCK : REQ_TRAJ;
		end
		OP_FIND_ZERO, OP_FIND_ZERO_REV, OP_FIND_LIMIT: begin
			if (item.op == OP_FIND_ZERO) begin
				mode = MODE_ZERO_NOT;
			end else if (item.op == OP_FIND_ZERO_REV) begin
				mode = MODE_ZERO_NOT_REV;
			end else begin
				mode = MODE_LIMIT;
			end
			speed     = item.start_speed;
			s.kind    = CMD_SPEED;
			s.value   = {{(WordW-SpeedW){speed[SpeedW-1]}}, speed};
			s.request = (item.op == OP_FIND_LIMIT) ? REQ_TRAJ_BLOCK : REQ_TRAJ;
		end
		default: begin
		end
		endcase
		s.mode     = mode;
		s.position = aux_pos;
		return s;
	endfunction

	task automatic report(input string field, input logic [WordW-1:0] got,
			input logic [WordW-1:0] want);
		$display("[%0t] result %0d, %s: got %0h, expected %0h", $time, result_no, field,
			got, want);
		mismatches++;
	endtask

	// Register writes, then the delivered result, then the accepted item.
	always @(posedge clk or negedge arst_n) begin
		motion_step_t want;
		if (!arst_n) begin
			blocking_on  = 1'b0;
			backoff      = BackoffReset;
			wait_ticks   = UnblockReset;
			window       = WindowReset;
			mode         = MODE_DONE;
			aux_pos      = '0;
			goto_target  = '0;
			unblock_left = '0;
			speed        = '0;
			result_no    = 0;
			mismatches   = 0;
			awaited_steps.delete();
			steps_awaited <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				REG_HANDLE_BLOCKING:  blocking_on = cfg.data[0];
				REG_BACKOFF_DISTANCE: backoff     = cfg.data;
				REG_UNBLOCK_WAIT:     wait_ticks  = cfg.data[CountW-1:0];
				REG_ARRIVAL_WINDOW:   window      = cfg.data;
				default: begin
				end
				endcase
			end
			if (result.valid && result.ready) begin
				result_no++;
				if (awaited_steps.size() == 0) begin
					report("result with no item waiting", result.mode_now, '0);
				end else begin
					want = awaited_steps.pop_front();
					if (result.mode_now !== want.mode)
						report("mode_now", result.mode_now, want.mode);
					if (result.aux_position !== want.position)
						report("aux_position", result.aux_position, want.position);
					if (result.cmd_kind !== want.kind)
						report("cmd_kind", result.cmd_kind, want.kind);
					if (result.cmd_value !== want.value)
						report("cmd_value", result.cmd_value, want.value);
					if (result.mode_request !== want.request)
						report("mode_request", result.mode_request, want.request);
					if (result.finished !== want.finished)
						report("finished", result.finished, want.finished);
					if (result.output_off !== want.output_off)
						report("output_off", result.output_off, want.output_off);
				end
			end
			if (item.valid && item.ready) begin
				awaited_steps.push_back(next_step());
			end
			steps_awaited <= awaited_steps.size();
		end
	end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the auxiliary motor trajectory sequencer. A directed run walks
// every operation and corner case, then random phases under several register
// settings play start commands followed by shaped ticks, mixed with noise.
// Both handshake sides idle at random; a checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	import amts_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int LongHold   = 80;
	localparam int PhaseItems = 90;

	localparam logic [OpW-1:0] OpSpareLow  = 3'd6;
	localparam logic [OpW-1:0] OpSpareHigh = 3'd7;

	typedef struct {
		logic [OpW-1:0]    op;
		logic [PosW-1:0]   goto_position;
		logic [SpeedW-1:0] start_speed;
		logic [PosW-1:0]   encoder_diff;
		logic              zero_seen;
		logic              blocked;
		logic              traj_enabled;
		logic              speed_use_pos;
		logic [WordW-1:0]  target_readback;
		logic [WordW-1:0]  pos_consign;
		logic [WordW-1:0]  pos_current;
	} cmd_item_t;

	logic clk = 1'b0;
	logic arst_n;
	int   cycle_count = 0;
	int   steps_awaited;
	int   mismatches;
	logic no_idle;
	logic long_hold;

	amts_in_if  item_ch ();
	amts_out_if result_ch ();
	amts_cfg_if cfg_ch ();

	aux_motor_trajectory_sequencer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	amts_motion_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item_ch),
		.result        (result_ch),
		.cfg           (cfg_ch),
		.steps_awaited (steps_awaited),
		.mismatches    (mismatches)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Idle length for either side: mostly none, sometimes short, rarely long.
	function automatic int pace_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_idle)
			return 0;
		if (roll < 65)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Result side: random stalls, and one long hold when asked for.
	initial begin
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			int stall;
			@(posedge clk);
			if (long_hold) begin
				result_ch.ready <= 1'b0;
				repeat (LongHold) @(posedge clk);
				long_hold = 1'b0;
			end else begin
				stall = pace_gap();
				if (stall == 0) begin
					result_ch.ready <= 1'b1;
				end else begin
					result_ch.ready <= 1'b0;
					repeat (stall - 1) @(posedge clk);
				end
			end
		end
	end

	function automatic cmd_item_t noise_item();
		cmd_item_t it;
		it.op              = OpW'($urandom_range(0, 7));
		it.goto_position   = PosW'($urandom);
		it.start_speed     = SpeedW'($urandom);
		it.encoder_diff    = PosW'($urandom);
		it.zero_seen       = 1'($urandom);
		it.blocked         = 1'($urandom);
		it.traj_enabled    = 1'($urandom);
		it.speed_use_pos   = 1'($urandom);
		it.target_readback = $urandom;
		it.pos_consign     = $urandom;
		it.pos_current     = $urandom;
		return it;
	endfunction

	function automatic cmd_item_t make_tick(input logic [PosW-1:0] diff, input logic zero,
			input logic blk);
		cmd_item_t it;
		it               = noise_item();
		it.op            = OP_TICK;
		it.encoder_diff  = diff;
		it.zero_seen     = zero;
		it.blocked       = blk;
		it.traj_enabled  = 1'b1;
		it.speed_use_pos = 1'b0;
		return it;
	endfunction

	function automatic cmd_item_t make_start(input op_t op, input logic [PosW-1:0] dest,
			input logic [SpeedW-1:0] spd);
		cmd_item_t it;
		it               = noise_item();
		it.op            = op;
		it.goto_position = dest;
		it.start_speed   = spd;
		return it;
	endfunction

	// Offers one item, waits for it to be taken, then idles at random.
	task automatic offer_item(input cmd_item_t it);
		int gap;
		item_ch.op              <= it.op;
		item_ch.goto_position   <= it.goto_position;
		item_ch.start_speed     <= it.start_speed;
		item_ch.encoder_diff    <= it.encoder_diff;
		item_ch.zero_seen       <= it.zero_seen;
		item_ch.blocked         <= it.blocked;
		item_ch.traj_enabled    <= it.traj_enabled;
		item_ch.speed_use_pos   <= it.speed_use_pos;
		item_ch.target_readback <= it.target_readback;
		item_ch.pos_consign     <= it.pos_consign;
		item_ch.pos_current     <= it.pos_current;
		item_ch.valid           <= 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		gap = pace_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering and waits until every awaited result has been delivered.
	task automatic settle();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (steps_awaited != 0);
		repeat (4) @(posedge clk);
	endtask

	// Offers one register write and waits for it to be taken; the caller
	// drops valid after the last write of a burst.
	task automatic write_reg(input reg_idx_t idx, input logic [CfgDatW-1:0] val);
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic apply_settings(input logic blk_on, input logic [PosW-1:0] back,
			input logic [CountW-1:0] wait_n, input logic [PosW-1:0] win);
		settle();
		write_reg(REG_HANDLE_BLOCKING, {{(CfgDatW-1){1'b0}}, blk_on});
		write_reg(REG_BACKOFF_DISTANCE, back);
		write_reg(REG_UNBLOCK_WAIT, {{(CfgDatW-CountW){1'b0}}, wait_n});
		write_reg(REG_ARRIVAL_WINDOW, win);
		cfg_ch.valid <= 1'b0;
	endtask

	// Every operation, the field extremes and the corner cases in turn.
	task automatic directed_run();
		cmd_item_t it;
		// Position wraps; ticks with trajectory control off only move it.
		it = make_tick(16'h7FFF, 1'b0, 1'b0);
		it.traj_enabled = 1'b0;
		offer_item(it);
		it = make_tick(16'h8000, 1'b0, 1'b0);
		it.traj_enabled = 1'b0;
		offer_item(it);
		// Spare op codes change nothing.
		it = noise_item();
		it.op = OpSpareLow;
		offer_item(it);
		it.op = OpSpareHigh;
		offer_item(it);
		// Goto without blocking detection, a difference of -2^31 that never
		// arrives, then blocking with the reset back-off.
		offer_item(make_start(OP_START_GOTO, 16'h0000, 8'h00));
		it = make_tick(16'h0000, 1'b0, 1'b0);
		it.target_readback = 32'h8000_0000;
		it.pos_current     = 32'h0000_0000;
		offer_item(it);
		offer_item(make_tick(16'h0001, 1'b0, 1'b1));

		apply_settings(1'b1, 16'h7FFF, 8'd2, 16'hFFFF);
		// Goto with blocking detection, back-off, retry and arrival.
		offer_item(make_start(OP_START_GOTO, 16'hFFFF, 8'hFF));
		offer_item(make_tick(16'h0010, 1'b0, 1'b1));
		offer_item(make_tick(16'hFFF0, 1'b0, 1'b0));
		offer_item(make_tick(16'h0000, 1'b0, 1'b0));
		it = make_tick(16'h0003, 1'b0, 1'b0);
		it.target_readback = it.pos_current + 32'd65534;
		offer_item(it);
		// Speed mode ends once the readback reaches the consign.
		offer_item(make_start(OP_START_SPEED, 16'h1234, 8'h7F));
		it = make_tick(16'h0002, 1'b0, 1'b0);
		it.speed_use_pos   = 1'b1;
		it.target_readback = it.pos_consign ^ 32'h1;
		offer_item(it);
		it.target_readback = it.pos_consign;
		offer_item(it);
		// Find zero forward at the most negative speed.
		offer_item(make_start(OP_FIND_ZERO, 16'h0000, 8'h80));
		offer_item(make_tick(16'h0005, 1'b0, 1'b0));
		offer_item(make_tick(16'h0005, 1'b1, 1'b0));
		offer_item(make_tick(16'h0005, 1'b1, 1'b0));
		offer_item(make_tick(16'h0005, 1'b0, 1'b0));
		// Find zero with reverse: the most negative speed saturates on negation.
		offer_item(make_start(OP_FIND_ZERO_REV, 16'hFFFF, 8'h80));
		offer_item(make_tick(16'hFFFB, 1'b1, 1'b0));
		offer_item(make_tick(16'hFFFB, 1'b0, 1'b0));
		// Find limit ends on blocking with the output forced off.
		offer_item(make_start(OP_FIND_LIMIT, 16'h0000, 8'h7F));
		offer_item(make_tick(16'h0100, 1'b0, 1'b0));
		offer_item(make_tick(16'h0100, 1'b0, 1'b1));
	endtask

	// One start command followed by ticks shaped to drive that mode through
	// its states, or now and then a stretch of unrelated items.
	task automatic play_sequence(output int counted);
		cmd_item_t it;
		op_t       start_op;
		int        len;
		int        i;
		int        roll;
		logic      zero_phase;
		logic      blk;
		counted = 0;
		roll    = $urandom_range(0, 9);
		len     = $urandom_range(2, 28);
		if (roll == 9) begin
			for (i = 0; i < len; i++) begin
				it = noise_item();
				offer_item(it);
				if (it.op <= OP_FIND_LIMIT)
					counted++;
			end
			return;
		end
		case (roll)
		0:       start_op = OP_START_SPEED;
		1, 2, 3: start_op = OP_START_GOTO;
		4:       start_op = OP_FIND_ZERO;
		5:       start_op = OP_FIND_ZERO_REV;
		6:       start_op = OP_FIND_LIMIT;
		default: start_op = OP_TICK;
		endcase
		if (start_op != OP_TICK) begin
			it    = noise_item();
			it.op = start_op;
			if ($urandom_range(0, 5) == 0)
				it.start_speed = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
			offer_item(it);
			counted++;
		end
		for (i = 0; i < len; i++) begin
			zero_phase = (i >= len / 3) && (i < (2 * len) / 3);
			zero_phase = zero_phase ^ ($urandom_range(0, 7) == 0);
			case (start_op)
			OP_START_GOTO: blk = ($urandom_range(0, 5) == 0);
			OP_FIND_LIMIT: blk = (i == len - 1) || ($urandom_range(0, 7) == 0);
			default:       blk = ($urandom_range(0, 9) == 0);
			endcase
			it = make_tick(PosW'(($urandom_range(0, 4) == 0) ? $urandom
				: $urandom_range(0, 200) - 100), zero_phase, blk);
			it.traj_enabled  = ($urandom_range(0, 9) != 0);
			it.speed_use_pos = ($urandom_range(0, 3) != 0);
			roll = $urandom_range(0, 99);
			if (start_op == OP_START_SPEED && roll < 30) begin
				it.target_readback = it.pos_consign;
			end else if (roll < 30) begin
				it.target_readback = it.pos_current + ($urandom_range(0, 800) - 400);
			end else if (roll < 35) begin
				it.target_readback = it.pos_current + 32'h8000_0000;
			end
			offer_item(it);
			counted++;
		end
	endtask

	task automatic random_phase(input int quota);
		int sent;
		int n;
		sent = 0;
		while (sent < quota) begin
			play_sequence(n);
			sent += n;
		end
	endtask

	initial begin
		int n;
		arst_n                  <= 1'b0;
		item_ch.valid           <= 1'b0;
		item_ch.op              <= OP_TICK;
		item_ch.goto_position   <= '0;
		item_ch.start_speed     <= '0;
		item_ch.encoder_diff    <= '0;
		item_ch.zero_seen       <= 1'b0;
		item_ch.blocked         <= 1'b0;
		item_ch.traj_enabled    <= 1'b0;
		item_ch.speed_use_pos   <= 1'b0;
		item_ch.target_readback <= '0;
		item_ch.pos_consign     <= '0;
		item_ch.pos_current     <= '0;
		cfg_ch.valid            <= 1'b0;
		cfg_ch.index            <= REG_HANDLE_BLOCKING;
		cfg_ch.data             <= '0;
		no_idle   = 1'b0;
		long_hold = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_run();

		// Low extremes, with both sides running flat out.
		apply_settings(1'b0, 16'h8000, 8'd1, 16'h0000);
		no_idle = 1'b1;
		random_phase(PhaseItems);
		no_idle = 1'b0;

		// High extremes; the result side holds off while items keep coming.
		apply_settings(1'b1, 16'h7FFF, 8'd255, 16'hFFFF);
		no_idle   = 1'b1;
		long_hold = 1'b1;
		random_phase(30);
		no_idle = 1'b0;
		random_phase(PhaseItems - 30);

		// A wait register of zero stands for the longest wait.
		apply_settings(1'b0, PosW'($urandom), 8'd0, 16'd300);
		random_phase(PhaseItems);

		apply_settings(1'b1, PosW'($urandom), CountW'($urandom_range(1, 40)),
			PosW'($urandom));
		random_phase(PhaseItems);

		apply_settings(1'b0, BackoffReset, UnblockReset, WindowReset);
		random_phase(PhaseItems);

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/amts_pkg.sv
hdl/amts_in_if.sv
hdl/amts_out_if.sv
hdl/amts_cfg_if.sv
hdl/aux_motor_trajectory_sequencer_unit.sv
test/amts_motion_checker.sv
test/testbench.sv
